### rtl/core/lcsr_pkg.sv
// Shared types and constants for the load cell converter serial reader.
// Used by lcsr_seq, lcsr_div and load_cell_adc_serial_reader_top; no dependencies.
`default_nettype none

package lcsr_pkg;

	localparam int RAW_W    = 24;   // width of the reported raw count
	localparam int WEIGHT_W = 40;   // width of the reported weight
	localparam int FRAC_W   = 16;   // numerator shift: 8 divisor bits plus 8 result bits
	localparam int DEN_W    = 24;   // width of the scale divisor
	localparam int TICK_W   = 18;   // holds poll_interval_us * ticks_per_microsecond
	localparam int POLL_W   = 16;

	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

	localparam logic [7:0]  TICKS_RST    = 8'd32;
	localparam logic [9:0]  INTERVAL_RST = 10'd10;
	localparam logic [15:0] TIMEOUT_RST  = 16'd2000;
	localparam logic [23:0] SCALE_RST    = 24'd256;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_MEASURE = 2'd1,
		ACT_TARE    = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		CFG_TICKS_PER_US  = 2'd0,
		CFG_POLL_INTERVAL = 2'd1,
		CFG_TIMEOUT_POLLS = 2'd2,
		CFG_SCALE_DIV     = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_POLL  = 3'd1,
		PH_HIGH  = 3'd2,
		PH_LOW   = 3'd3,
		PH_EXTRA = 3'd4
	} phase_t;

	// Timing registers seen by the sequencer.
	typedef struct packed {
		logic [7:0]        ticks_per_us;
		logic [9:0]        poll_interval;
		logic [POLL_W-1:0] timeout_polls;
	} seq_cfg_t;

	// What one tick of the sequencer produces.
	typedef struct packed {
		logic             sck;
		logic             busy;
		logic             done;
		logic             was_tare;
		logic             timed_out;
		logic [RAW_W-1:0] raw;
		logic             need_div;
	} step_res_t;

endpackage

`default_nettype wire

### rtl/core/load_cell_adc_serial_reader_top.sv
// Top level of the load cell converter serial reader.
// Depends on lcsr_pkg, lcsr_seq and lcsr_div.
`default_nettype none

// Each input transfer is one tick of the converter pin interface and yields exactly one
// result transfer carrying the SCK level, the busy flag and, on the tick that ends a read,
// the raw offset-binary count and the weight. A start (measurement or tare) is ignored while
// a read runs. The block polls the data line every poll interval until it goes low, giving
// up with a zero count and the timeout flag after more than timeout_polls failed polls; it
// then clocks DATA_BITS bits MSB first, sampling on the last SCK high tick, and adds one
// extra pulse. A tare stores the count as the offset; a measurement subtracts the offset,
// clamps at zero and divides by scale_divisor_q8 to give a weight with 8 fractional bits.
// A tick is taken whenever the result register is free or being emptied, except after the
// tick that ends a measurement with a positive difference: the weight comes from a
// restoring divider that produces one quotient bit per cycle, and the input is stalled
// until it finishes. The result sits in an output register, so the next tick is taken
// in the same cycle as the previous result is transferred. Configuration is always ready
// and is expected to be written only while no read is in progress.
module load_cell_adc_serial_reader_top #(
	parameter int DATA_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic        dt_level,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             sck_level,
	output logic             busy_res,
	output logic             done_res,
	output logic             was_tare,
	output logic             timed_out,
	output logic [23:0]      raw_count,
	output logic [39:0]      weight_q8,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	localparam int NUM_W = DATA_BITS + lcsr_pkg::FRAC_W;
	localparam int QX_W  = (NUM_W > lcsr_pkg::WEIGHT_W) ? NUM_W : lcsr_pkg::WEIGHT_W;

	logic [7:0]                   ticks_q;
	logic [9:0]                   interval_q;
	logic [15:0]                  timeout_q;
	logic [23:0]                  scale_q;
	lcsr_pkg::seq_cfg_t           seq_cfg;
	lcsr_pkg::step_res_t          res;
	logic [DATA_BITS-1:0]         diff;
	logic [NUM_W-1:0]             quot;
	logic [QX_W-1:0]              quot_x;
	logic [lcsr_pkg::WEIGHT_W-1:0] weight_sat;
	logic [lcsr_pkg::DEN_W-1:0]   divisor;
	logic                         accept, div_start, div_busy, div_done, out_valid_q;

	// Configuration registers; the port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q    <= lcsr_pkg::TICKS_RST;
			interval_q <= lcsr_pkg::INTERVAL_RST;
			timeout_q  <= lcsr_pkg::TIMEOUT_RST;
			scale_q    <= lcsr_pkg::SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (lcsr_pkg::cfg_idx_t'(cfg_index))
				lcsr_pkg::CFG_TICKS_PER_US:  ticks_q    <= cfg_data[7:0];
				lcsr_pkg::CFG_POLL_INTERVAL: interval_q <= cfg_data[9:0];
				lcsr_pkg::CFG_TIMEOUT_POLLS: timeout_q  <= cfg_data[15:0];
				lcsr_pkg::CFG_SCALE_DIV:     scale_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign seq_cfg.ticks_per_us  = ticks_q;
	assign seq_cfg.poll_interval = interval_q;
	assign seq_cfg.timeout_polls = timeout_q;

	// A tick is refused while a division runs or completes, and while the result
	// register holds a transfer the consumer is not taking.
	assign in_stall  = div_busy | div_done | (out_valid_q & out_stall);
	assign accept    = in_valid & ~in_stall;
	assign div_start = accept & res.need_div;
	assign divisor   = (scale_q == '0) ? lcsr_pkg::DEN_W'(1) : scale_q;

	lcsr_seq #(
		.DATA_BITS(DATA_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (accept),
		.action   (action),
		.dt_level (dt_level),
		.cfg      (seq_cfg),
		.res      (res),
		.diff     (diff)
	);

	lcsr_div #(
		.DATA_BITS(DATA_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.diff    (diff),
		.divisor (divisor),
		.busy    (div_busy),
		.done    (div_done),
		.quot    (quot)
	);

	// Only wider count widths can push the quotient past 40 bits.
	always_comb begin
		quot_x     = QX_W'(quot);
		weight_sat = (quot_x > QX_W'(lcsr_pkg::WEIGHT_MAX)) ? lcsr_pkg::WEIGHT_MAX
			: lcsr_pkg::WEIGHT_W'(quot_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			// A result waiting on the division is released when the divider finishes.
			out_valid_q <= ~res.need_div;
		end else if (div_done) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sck_level <= res.sck;
			busy_res  <= res.busy;
			done_res  <= res.done;
			was_tare  <= res.was_tare;
			timed_out <= res.timed_out;
			raw_count <= res.raw;
			weight_q8 <= '0;
		end else if (div_done) begin
			weight_q8 <= weight_sat;
		end
	end

	assign out_valid = out_valid_q;

	a_div_blocks_output: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !out_valid_q)
		else $error("result presented while the weight division is still running");

	a_div_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_busy && !out_valid_q)
		else $error("measurement needing a division did not start the divider");

	a_timeout_zero_raw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out |-> raw_count == '0 && weight_q8 == '0 && done_res)
		else $error("timed-out read reported a non-zero count or weight");

	a_tare_no_weight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_tare |-> weight_q8 == '0 && done_res)
		else $error("tare read reported a weight");

	a_idle_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> raw_count == '0 && !was_tare && !timed_out)
		else $error("result fields set on a tick that did not finish a read");

endmodule

`default_nettype wire

### rtl/core/lcsr_seq.sv
// Tick sequencer: polling, SCK generation, serial capture and tare offset store.
// Depends on lcsr_pkg.
`default_nettype none

module lcsr_seq #(
	parameter int DATA_BITS = 24
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    step_en,
	input  wire logic [1:0]              action,
	input  wire logic                    dt_level,
	input  wire lcsr_pkg::seq_cfg_t      cfg,
	output lcsr_pkg::step_res_t          res,
	output logic [DATA_BITS-1:0]         diff
);

	localparam int BW = $clog2(DATA_BITS + 1);
	localparam logic [DATA_BITS-1:0] SIGN_BIT = {1'b1, {(DATA_BITS-1){1'b0}}};

	lcsr_pkg::phase_t                phase_q, phase_d;
	logic [lcsr_pkg::TICK_W-1:0]     tick_q, tick_d, tick_inc, half_w, poll_len;
	logic [lcsr_pkg::POLL_W-1:0]     poll_q, poll_d;
	logic [BW-1:0]                   bit_q, bit_d, bit_inc;
	logic [DATA_BITS-1:0]            shift_q, shift_d, tare_q, tare_d, raw_w;
	logic                            tare_op_q, tare_op_d, sck_q, sck_d;
	logic                            fin, fin_to;
	logic [7:0]                      half8;
	logic [9:0]                      intv;

	always_comb begin
		half8    = (cfg.ticks_per_us == 8'd0) ? 8'd1 : cfg.ticks_per_us;
		intv     = (cfg.poll_interval == 10'd0) ? 10'd1 : cfg.poll_interval;
		half_w   = lcsr_pkg::TICK_W'(half8);
		poll_len = lcsr_pkg::TICK_W'(intv) * half_w;
		tick_inc = tick_q + 1'b1;
		bit_inc  = bit_q + 1'b1;

		phase_d   = phase_q;
		tick_d    = tick_q;
		poll_d    = poll_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		tare_op_d = tare_op_q;
		sck_d     = sck_q;
		fin       = 1'b0;
		fin_to    = 1'b0;

		case (phase_q)
			lcsr_pkg::PH_IDLE: begin
				if (action == lcsr_pkg::ACT_MEASURE || action == lcsr_pkg::ACT_TARE) begin
					tare_op_d = (action == lcsr_pkg::ACT_TARE);
					phase_d   = lcsr_pkg::PH_POLL;
					tick_d    = '0;
					poll_d    = '0;
					bit_d     = '0;
					shift_d   = '0;
					sck_d     = 1'b0;
				end
			end
			lcsr_pkg::PH_POLL: begin
				if (tick_q == '0 && !dt_level) begin
					// Data ready: raise SCK for the first bit.
					phase_d = lcsr_pkg::PH_HIGH;
					sck_d   = 1'b1;
					tick_d  = '0;
					bit_d   = '0;
					shift_d = '0;
				end else begin
					tick_d = tick_inc;
					if (tick_inc >= poll_len) begin
						tick_d = '0;
						if (poll_q >= cfg.timeout_polls) begin
							fin    = 1'b1;
							fin_to = 1'b1;
						end else begin
							poll_d = poll_q + 1'b1;
						end
					end
				end
			end
			lcsr_pkg::PH_HIGH: begin
				tick_d = tick_inc;
				if (tick_inc >= half_w) begin
					// Sample on the last high tick, MSB first.
					shift_d = {shift_q[DATA_BITS-2:0], dt_level};
					sck_d   = 1'b0;
					phase_d = lcsr_pkg::PH_LOW;
					tick_d  = '0;
				end
			end
			lcsr_pkg::PH_LOW: begin
				tick_d = tick_inc;
				if (tick_inc >= half_w) begin
					bit_d   = bit_inc;
					phase_d = (bit_inc >= BW'(DATA_BITS)) ? lcsr_pkg::PH_EXTRA
						: lcsr_pkg::PH_HIGH;
					sck_d   = 1'b1;
					tick_d  = '0;
				end
			end
			lcsr_pkg::PH_EXTRA: begin
				tick_d = tick_inc;
				if (tick_inc >= half_w) begin
					fin = 1'b1;
				end
			end
			default: begin
				phase_d = lcsr_pkg::PH_IDLE;
				sck_d   = 1'b0;
			end
		endcase

		raw_w  = fin_to ? '0 : (shift_q ^ SIGN_BIT);
		tare_d = tare_q;
		if (fin) begin
			phase_d = lcsr_pkg::PH_IDLE;
			sck_d   = 1'b0;
			tick_d  = '0;
			poll_d  = '0;
			bit_d   = '0;
			if (tare_op_q) begin
				tare_d = raw_w;
			end
		end

		diff          = raw_w - tare_q;
		res.sck       = sck_d;
		res.busy      = (phase_d != lcsr_pkg::PH_IDLE);
		res.done      = fin;
		res.was_tare  = fin & tare_op_q;
		res.timed_out = fin_to;
		res.raw       = fin ? lcsr_pkg::RAW_W'(raw_w) : '0;
		res.need_div  = fin && !tare_op_q && (raw_w > tare_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lcsr_pkg::PH_IDLE;
			tick_q    <= '0;
			poll_q    <= '0;
			bit_q     <= '0;
			shift_q   <= '0;
			tare_q    <= '0;
			tare_op_q <= 1'b0;
			sck_q     <= 1'b0;
		end else if (step_en) begin
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			poll_q    <= poll_d;
			bit_q     <= bit_d;
			shift_q   <= shift_d;
			tare_q    <= tare_d;
			tare_op_q <= tare_op_d;
			sck_q     <= sck_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/lcsr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, for the weight.
// Depends on lcsr_pkg.
`default_nettype none

module lcsr_div #(
	parameter int DATA_BITS = 24
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire logic [DATA_BITS-1:0]                   diff,
	input  wire logic [lcsr_pkg::DEN_W-1:0]             divisor,
	output logic                                        busy,
	output logic                                        done,
	output logic [DATA_BITS+lcsr_pkg::FRAC_W-1:0]       quot
);

	localparam int NUM_W = DATA_BITS + lcsr_pkg::FRAC_W;
	localparam int CW    = $clog2(NUM_W + 1);
	localparam int DW    = lcsr_pkg::DEN_W;

	logic [NUM_W-1:0] num_q;
	logic [DW-1:0]    rem_q, den_q, rem_nxt;
	logic [DW:0]      trial;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q, ge;

	always_comb begin
		trial   = {rem_q, num_q[NUM_W-1]};
		ge      = (trial >= {1'b0, den_q});
		rem_nxt = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The numerator shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {diff, {lcsr_pkg::FRAC_W{1'b0}}};
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = num_q;

endmodule

`default_nettype wire

### bench/load_cell_adc_serial_reader_top_tb.sv
// Self-checking testbench for load_cell_adc_serial_reader_top.
// Depends on lcsr_pkg and the reader RTL; it predicts every result transfer from its own
// tick-by-tick model of the reader and checks all seven result fields.
module load_cell_adc_serial_reader_top_tb;

	localparam int DATA_BITS = 24;
	// The action code with no meaning; the reader must treat it as a plain tick.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = DATA_BITS + 40;

	// One input tick as offered to the reader.
	typedef struct packed {
		logic [1:0] act;
		logic       dt;
	} tick_t;

	// One result transfer as the reader should present it.
	typedef struct packed {
		logic        sck;
		logic        busy;
		logic        done;
		logic        tare;
		logic        tmo;
		logic [23:0] raw;
		logic [39:0] weight;
	} reading_t;

	// Our own copy of the reader's sequencing state.
	typedef struct packed {
		lcsr_pkg::phase_t      ph;
		logic [17:0]           tick;
		logic [15:0]           polls;
		logic [5:0]            bits;
		logic [DATA_BITS-1:0]  shift;
		logic [23:0]           offset;
		logic                  tare_op;
		logic                  sck;
	} reader_state_t;

	typedef struct packed {
		logic [7:0]  ticks;
		logic [9:0]  interval;
		logic [15:0] timeout;
		logic [23:0] scale;
	} reader_cfg_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = lcsr_pkg::ACT_NONE;
	logic        dt_level = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        sck_level;
	logic        busy_res;
	logic        done_res;
	logic        was_tare;
	logic        timed_out;
	logic [23:0] raw_count;
	logic [39:0] weight_q8;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = lcsr_pkg::CFG_TICKS_PER_US;
	logic [23:0] cfg_data = '0;

	load_cell_adc_serial_reader_top #(
		.DATA_BITS(DATA_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.dt_level(dt_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sck_level(sck_level),
		.busy_res(busy_res),
		.done_res(done_res),
		.was_tare(was_tare),
		.timed_out(timed_out),
		.raw_count(raw_count),
		.weight_q8(weight_q8),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// The register copy is shared by the planner and the checker. That is safe because
	// registers are only written once every planned tick has been transferred and checked.
	reader_cfg_t   cfg;
	// plan runs ahead as ticks are queued; live follows the ticks the reader accepts.
	reader_state_t plan;
	reader_state_t live;

	tick_t    pending[$];
	reading_t readings_due[$];

	int          n_fail = 0;
	int          n_ticks = 0;
	int          n_planned = 0;
	int          n_reads = 0;
	int          n_tares = 0;
	int          n_gave_up = 0;
	int          n_writes = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	bit          quiet = 1'b0;
	int          holds_asked = 0;
	int          holds_served = 0;
	int          rx_hold_left = 0;
	int          tx_gap = 0;
	int          rx_gap = 0;
	tick_t       next_tick;
	reading_t    want;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Ends a read: a tare keeps the count as the new offset, a measurement turns the
	// clamped difference into a weight with eight fractional bits.
	function automatic void close_read(inout reader_state_t s, inout reading_t r,
			input logic gave_up);
		logic [DATA_BITS-1:0] flipped;
		logic [23:0]          raw;
		logic [23:0]          diff;
		logic [23:0]          div;
		logic [63:0]          quotient;
		logic [39:0]          weight;
		flipped = s.shift;
		flipped[DATA_BITS-1] = ~flipped[DATA_BITS-1];
		raw = gave_up ? 24'd0 : lcsr_pkg::RAW_W'(flipped);
		weight = '0;
		if (s.tare_op) begin
			s.offset = raw;
		end else if (raw > s.offset) begin
			diff = raw - s.offset;
			div = (cfg.scale == 24'd0) ? 24'd1 : cfg.scale;
			quotient = {24'd0, diff, 16'd0} / {40'd0, div};
			weight = (quotient > {24'd0, lcsr_pkg::WEIGHT_MAX}) ? lcsr_pkg::WEIGHT_MAX
				: quotient[39:0];
		end
		r.done = 1'b1;
		r.tare = s.tare_op;
		r.tmo = gave_up;
		r.raw = raw;
		r.weight = weight;
		s.ph = lcsr_pkg::PH_IDLE;
		s.sck = 1'b0;
		s.tick = '0;
		s.polls = '0;
		s.bits = '0;
	endfunction

	// Advances a reader state by one tick and returns the result that tick produces.
	function automatic reading_t reader_tick(inout reader_state_t s, input logic [1:0] act,
			input logic dt);
		reading_t    r;
		int unsigned half;
		int unsigned wait_len;
		r = '0;
		half = (cfg.ticks == 8'd0) ? 1 : cfg.ticks;
		case (s.ph)
			lcsr_pkg::PH_IDLE: begin
				if (act == lcsr_pkg::ACT_MEASURE || act == lcsr_pkg::ACT_TARE) begin
					s.tare_op = (act == lcsr_pkg::ACT_TARE);
					s.ph = lcsr_pkg::PH_POLL;
					s.tick = '0;
					s.polls = '0;
					s.bits = '0;
					s.shift = '0;
					s.sck = 1'b0;
				end
			end
			lcsr_pkg::PH_POLL: begin
				if (s.tick == '0 && !dt) begin
					s.ph = lcsr_pkg::PH_HIGH;
					s.sck = 1'b1;
					s.tick = '0;
					s.bits = '0;
					s.shift = '0;
				end else begin
					wait_len = ((cfg.interval == 10'd0) ? 1 : cfg.interval) * half;
					s.tick = s.tick + 18'd1;
					if (s.tick >= wait_len) begin
						s.tick = '0;
						if (s.polls >= cfg.timeout)
							close_read(s, r, 1'b1);
						else
							s.polls = s.polls + 16'd1;
					end
				end
			end
			lcsr_pkg::PH_HIGH: begin
				s.tick = s.tick + 18'd1;
				if (s.tick >= half) begin
					s.shift = {s.shift[DATA_BITS-2:0], dt};
					s.sck = 1'b0;
					s.ph = lcsr_pkg::PH_LOW;
					s.tick = '0;
				end
			end
			lcsr_pkg::PH_LOW: begin
				s.tick = s.tick + 18'd1;
				if (s.tick >= half) begin
					s.bits = s.bits + 6'd1;
					s.ph = (s.bits >= DATA_BITS) ? lcsr_pkg::PH_EXTRA : lcsr_pkg::PH_HIGH;
					s.sck = 1'b1;
					s.tick = '0;
				end
			end
			lcsr_pkg::PH_EXTRA: begin
				s.tick = s.tick + 18'd1;
				if (s.tick >= half)
					close_read(s, r, 1'b0);
			end
			default: begin
				s.ph = lcsr_pkg::PH_IDLE;
				s.sck = 1'b0;
			end
		endcase
		r.sck = s.sck;
		r.busy = (s.ph != lcsr_pkg::PH_IDLE);
		return r;
	endfunction

	function automatic void push_tick(input logic [1:0] act, input logic dt);
		tick_t    t;
		reading_t ignored;
		t.act = act;
		t.dt = dt;
		pending.push_back(t);
		ignored = reader_tick(plan, act, dt);
		n_planned++;
	endfunction

	// Idle ticks between reads, with both the plain code and the unused one.
	function automatic void plan_idle(input int unsigned n);
		logic [1:0] act;
		repeat (n) begin
			act = $urandom_range(0, 1) ? lcsr_pkg::ACT_NONE : ACT_UNUSED;
			push_tick(act, 1'($urandom_range(0, 1)));
		end
	endfunction

	// Queues one whole read. The converter model answers the first `fails` data-ready
	// checks with a high line, then presents raw_val (offset binary) bit by bit, setting
	// the line only on the tick where the reader samples it. With noise, busy ticks carry
	// random actions that the reader must ignore; at full noise every busy tick is a start.
	function automatic void plan_read(input logic [1:0] kind, input int unsigned fails,
			input logic [23:0] raw_val, input int unsigned noise_pct);
		logic [DATA_BITS-1:0] word;
		int unsigned          checks;
		int unsigned          half;
		logic [1:0]           act;
		logic                 dt;
		word = DATA_BITS'(raw_val);
		word[DATA_BITS-1] = ~word[DATA_BITS-1];
		checks = 0;
		push_tick(kind, 1'($urandom_range(0, 1)));
		while (plan.ph != lcsr_pkg::PH_IDLE) begin
			half = (cfg.ticks == 8'd0) ? 1 : cfg.ticks;
			dt = 1'($urandom_range(0, 1));
			act = lcsr_pkg::ACT_NONE;
			if (noise_pct >= 100)
				act = $urandom_range(0, 1) ? lcsr_pkg::ACT_MEASURE : lcsr_pkg::ACT_TARE;
			else if ($urandom_range(0, 99) < noise_pct)
				act = 2'($urandom_range(0, 3));
			if (plan.ph == lcsr_pkg::PH_POLL && plan.tick == '0) begin
				dt = (checks < fails);
				checks++;
			end else if (plan.ph == lcsr_pkg::PH_HIGH && plan.tick + 1 >= half) begin
				dt = word[DATA_BITS-1-plan.bits];
			end
			push_tick(act, dt);
		end
	endfunction

	// Sender: offers queued ticks, with random idle bursts between them; a tick is held while in_stall is high.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= lcsr_pkg::ACT_NONE;
			dt_level <= 1'b0;
			tx_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				readings_due.push_back(reader_tick(live, action, dt_level));
				n_ticks++;
			end
			if (!in_valid || !in_stall) begin
				if (tx_gap != 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
					tx_gap = $urandom_range(1, 12) - 1;
					in_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					next_tick = pending.pop_front();
					in_valid <= 1'b1;
					action <= next_tick.act;
					dt_level <= next_tick.dt;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-offs, counted here and requested by the stimulus process.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold_left <= 0;
			holds_served <= 0;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end else if (holds_served != holds_asked) begin
			rx_hold_left <= HOLD_CYCLES;
			holds_served <= holds_served + 1;
		end
	end

	task automatic check_field(input string name, input logic [39:0] exp_val,
			input logic [39:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			n_fail++;
		end
	endtask

	// Receiver: checks each result transfer against the oldest prediction and stalls at
	// random, or for a whole hold-off when one is running.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (readings_due.size() == 0) begin
					$error("result transfer with no tick outstanding");
					n_fail++;
				end else begin
					want = readings_due.pop_front();
					check_field("sck_level", want.sck, sck_level);
					check_field("busy_res", want.busy, busy_res);
					check_field("done_res", want.done, done_res);
					check_field("was_tare", want.tare, was_tare);
					check_field("timed_out", want.tmo, timed_out);
					check_field("raw_count", want.raw, raw_count);
					check_field("weight_q8", want.weight, weight_q8);
					if (want.done) begin
						n_reads++;
						if (want.tare)
							n_tares++;
						if (want.tmo)
							n_gave_up++;
					end
				end
			end
			if (rx_hold_left != 0) begin
				out_stall <= 1'b1;
			end else if (rx_gap != 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
				rx_gap = $urandom_range(1, 12) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Writes one register. The reader is idle whenever this is called, so the predictor's
	// copy is updated at the edge where the write transfer happens.
	task automatic write_reg(input lcsr_pkg::cfg_idx_t idx, input logic [23:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			lcsr_pkg::CFG_TICKS_PER_US:  cfg.ticks = val[7:0];
			lcsr_pkg::CFG_POLL_INTERVAL: cfg.interval = val[9:0];
			lcsr_pkg::CFG_TIMEOUT_POLLS: cfg.timeout = val[15:0];
			lcsr_pkg::CFG_SCALE_DIV:     cfg.scale = val;
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
	endtask

	task automatic write_all(input logic [7:0] ticks, input logic [9:0] interval,
			input logic [15:0] timeout, input logic [23:0] scale);
		write_reg(lcsr_pkg::CFG_TICKS_PER_US, {16'd0, ticks});
		write_reg(lcsr_pkg::CFG_POLL_INTERVAL, {14'd0, interval});
		write_reg(lcsr_pkg::CFG_TIMEOUT_POLLS, {8'd0, timeout});
		write_reg(lcsr_pkg::CFG_SCALE_DIV, scale);
	endtask

	// Waits, on falling edges so as not to race the clocked processes, until every queued
	// tick has been transferred and every predicted result has been checked.
	task automatic settle();
		@(negedge clk);
		while (pending.size() != 0 || in_valid || readings_due.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [23:0] pick_raw();
		case ($urandom_range(0, 5))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return plan.offset + 24'($urandom_range(0, 2)) - 24'd1;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [23:0] pick_scale();
		case ($urandom_range(0, 3))
			0: return 24'($urandom_range(1, 24'hFFFFFF));
			1: return 24'($urandom_range(1, 2048));
			2: return lcsr_pkg::SCALE_RST;
			default: return 24'($urandom_range(0, 3));
		endcase
	endfunction

	initial begin
		int unsigned fails;
		int          rand_start;
		int          rand_reads;
		logic [1:0]  kind;
		bit          first;
		cfg.ticks = lcsr_pkg::TICKS_RST;
		cfg.interval = lcsr_pkg::INTERVAL_RST;
		cfg.timeout = lcsr_pkg::TIMEOUT_RST;
		cfg.scale = lcsr_pkg::SCALE_RST;
		plan = '0;
		plan.ph = lcsr_pkg::PH_IDLE;
		live = plan;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed cases at the shortest SCK half-period; the scale divisor keeps its reset value.
		tx_idle_pct = 15;
		rx_idle_pct = 15;
		write_reg(lcsr_pkg::CFG_TICKS_PER_US, 24'd1);
		write_reg(lcsr_pkg::CFG_POLL_INTERVAL, 24'd2);
		write_reg(lcsr_pkg::CFG_TIMEOUT_POLLS, 24'd3);
		push_tick(lcsr_pkg::ACT_NONE, 1'b0);
		push_tick(ACT_UNUSED, 1'b1);
		push_tick(ACT_UNUSED, 1'b0);
		push_tick(lcsr_pkg::ACT_NONE, 1'b1);
		plan_read(lcsr_pkg::ACT_TARE, 0, 24'h000000, 0);
		plan_read(lcsr_pkg::ACT_MEASURE, 2, 24'hFFFFFF, 0);
		plan_read(lcsr_pkg::ACT_MEASURE, 1, 24'h000000, 0);
		plan_read(lcsr_pkg::ACT_TARE, 3, 24'h7FFFFF, 0);
		// Below, equal to and just above the stored offset.
		plan_read(lcsr_pkg::ACT_MEASURE, 0, 24'h7FFFFE, 0);
		plan_read(lcsr_pkg::ACT_MEASURE, 0, 24'h7FFFFF, 0);
		plan_read(lcsr_pkg::ACT_MEASURE, 0, 24'h800000, 0);
		// A measurement that gives up, then a tare that gives up and so clears the offset.
		plan_read(lcsr_pkg::ACT_MEASURE, 4, 24'h123456, 0);
		plan_read(lcsr_pkg::ACT_TARE, 9, 24'h654321, 0);
		// Starts on every busy tick, the finishing one included, must all be ignored.
		plan_read(lcsr_pkg::ACT_MEASURE, 0, 24'hA5C30F, 100);
		plan_read(lcsr_pkg::ACT_TARE, 1, 24'h5A3CF0, 100);
		plan_read(lcsr_pkg::ACT_TARE, 0, 24'h000000, 0);
		settle();

		// Smallest divisor gives the largest weight; zero ticks, interval and timeout
		// behave as one, one and "give up after the first failed check".
		write_all(8'd0, 10'd0, 16'd0, 24'd1);
		plan_read(lcsr_pkg::ACT_MEASURE, 0, 24'hFFFFFF, 0);
		plan_read(lcsr_pkg::ACT_MEASURE, 1, 24'hFFFFFF, 0);
		settle();
		write_reg(lcsr_pkg::CFG_SCALE_DIV, 24'd0);
		plan_read(lcsr_pkg::ACT_MEASURE, 0, 24'hFFFFFF, 0);
		settle();
		write_reg(lcsr_pkg::CFG_SCALE_DIV, 24'hFFFFFF);
		plan_read(lcsr_pkg::ACT_MEASURE, 0, 24'hFFFFFF, 0);
		plan_read(lcsr_pkg::ACT_MEASURE, 0, 24'h000001, 0);
		settle();

		// The largest timeout, with the shortest timing.
		write_all(8'd1, 10'd1, 16'd65535, 24'd100);
		plan_read(lcsr_pkg::ACT_MEASURE, 3, 24'($urandom), 0);
		settle();

		// Random phases: short timings so that many reads fit, a fresh register setting
		// for each phase, and sometimes no idling at all.
		rand_start = n_planned;
		rand_reads = 0;
		first = 1'b1;
		while (n_planned - rand_start < 300 || rand_reads < 4) begin
			write_all(8'($urandom_range(0, 2)), 10'($urandom_range(0, 4)),
				16'($urandom_range(0, 5)), pick_scale());
			case ($urandom_range(0, 2))
				0: begin tx_idle_pct = 0; rx_idle_pct = 0; end
				1: begin tx_idle_pct = 8; rx_idle_pct = 20; end
				default: begin tx_idle_pct = 25; rx_idle_pct = 8; end
			endcase
			repeat ($urandom_range(2, 4)) begin
				plan_idle($urandom_range(0, 4));
				kind = ($urandom_range(0, 9) < 3) ? lcsr_pkg::ACT_TARE : lcsr_pkg::ACT_MEASURE;
				if ($urandom_range(0, 5) == 0)
					fails = cfg.timeout + 1;
				else
					fails = $urandom_range(0, cfg.timeout);
				plan_read(kind, fails, pick_raw(), ($urandom_range(0, 2) == 0) ? 30 : 0);
				rand_reads++;
				// Once in the run, the receiver holds off for a long stretch while ticks keep coming,
				// so the reader fills up and must stall its input.
				if (first) begin
					holds_asked++;
					first = 1'b0;
				end
				if ($urandom_range(0, 15) == 0)
					settle();
			end
			settle();
		end

		// A last phase with no idling on either side.
		quiet = 1'b1;
		write_all(8'd1, 10'd3, 16'd2, 24'($urandom_range(1, 24'hFFFFFF)));
		repeat (3) begin
			plan_idle($urandom_range(0, 3));
			plan_read(($urandom_range(0, 1) != 0) ? lcsr_pkg::ACT_TARE : lcsr_pkg::ACT_MEASURE,
				$urandom_range(0, 3), pick_raw(), 0);
		end
		settle();
		// Anything the reader sends now is a result with no tick behind it.
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d tick transfers over %0d register writes.", n_ticks, n_writes);
		$display("Completed reads: %0d, of which %0d tares and %0d gave up waiting.",
			n_reads, n_tares, n_gave_up);
		if (n_fail == 0) begin
			$display("load_cell_adc_serial_reader_top_tb passed");
		end else begin
			$display("load_cell_adc_serial_reader_top_tb failed");
		end
		$finish;
	end

	// Even with every tick meeting the longest idle bursts on both sides and every
	// measurement waiting on the divider, the run ends well before this timeout, which
	// would report a failure.
	initial begin
		#16_000_000;
		$display("load_cell_adc_serial_reader_top_tb failed");
		$finish;
	end

endmodule

### files.f
rtl/core/lcsr_pkg.sv
rtl/core/lcsr_seq.sv
rtl/core/lcsr_div.sv
rtl/core/load_cell_adc_serial_reader_top.sv
bench/load_cell_adc_serial_reader_top_tb.sv
